// ===== rtl/psg_pkg.sv =====
// shared constants, types and tables for the sound generator
package psg_pkg;

  localparam logic [31:0] BASE_RESET = 32'h28959bec;
  localparam logic [31:0] STEP_MAX = 32'h80000000;
  localparam int OVERSAMPLE_DEF = 16;

  localparam logic [1:0] OP_LATCH = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  function automatic logic [13:0] level(input logic [3:0] i);
    logic [13:0] r;
    begin
      case (i)
        4'd0: r = 14'h0000;
        4'd1: r = 14'h004f;
        4'd2: r = 14'h00b4;
        4'd3: r = 14'h0133;
        4'd4: r = 14'h01d4;
        4'd5: r = 14'h029f;
        4'd6: r = 14'h03a1;
        4'd7: r = 14'h04e7;
        4'd8: r = 14'h0683;
        4'd9: r = 14'h088c;
        4'd10: r = 14'h0b1f;
        4'd11: r = 14'h0e62;
        4'd12: r = 14'h1281;
        4'd13: r = 14'h17b8;
        4'd14: r = 14'h1e50;
        default: r = 14'h26a9;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] wmask(input logic [3:0] i);
    logic [7:0] r;
    begin
      case (i)
        4'd1, 4'd3, 4'd5, 4'd13: r = 8'h0f;
        4'd6, 4'd8, 4'd9, 4'd10: r = 8'h1f;
        4'd7: r = 8'h3f;
        default: r = 8'hff;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/psg_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module psg_div (
  input  logic               clk,
  input  logic               rst,
  input  psg_pkg::div_req_t  req,
  output psg_pkg::div_rsp_t  rsp
);
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.num;
        rem <= '0;
        den <= req.den;
        cnt <= 6'd32;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = '{done, quo};
endmodule

// ===== rtl/psg_tone_noise_envelope_mixer.sv =====
// top level: register file, sequencer for ticks and step updates
// usage
//   items enter on opcode/data_in/ext_port_value with in_valid, in_stall
//   back to the sender; one result per item leaves on the output port with
//   out_valid, out_stall driven by the receiver
//   the phase step numerator is written over cfg_valid/cfg_ready; the user
//   must write it only while idle, and the block has no check for this
// sequence
//   latch and read pass straight to the result; a data write to a period
//   register waits on the one-bit-a-cycle divider for its new step
//   tick: the noise shifts (up to 8), envelope step, the tone substeps and
//   mixing, one per cycle through a shared adder, then filters and output
// reset
//   rst sets all but output data, port and work regs to power-on values
// stall
//   a result is held in the output register while out_stall is high; the
//   next item is only taken once the result has been transferred
module psg_tone_noise_envelope_mixer #(
  parameter int OVERSAMPLE = psg_pkg::OVERSAMPLE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [7:0]         data_in,
  input  logic [7:0]         ext_port_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_data,
  output logic signed [20:0] sample_out,
  output logic               port_write_valid,
  output logic               port_select,
  output logic [7:0]         port_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  localparam int KW = $clog2(OVERSAMPLE + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_NOISE, S_ENV, S_TONE, S_MIX, S_DC1, S_DC2, S_LP1, S_LP2, S_LP3,
    S_OUT, S_DONE
  } state_t;

  state_t state;
  logic [31:0] base;
  logic [3:0]  addr;
  logic [7:0]  regs [16];
  logic [31:0] tph [3];
  logic [31:0] tstep [3];
  logic [31:0] nph, nstep, estep, eph;
  logic [16:0] nshift;
  logic        nlevel;
  logic [3:0]  eshape;
  logic signed [19:0] dcv, lpv;
  logic [15:0] pmix;
  logic [1:0]  ch;
  logic [KW-1:0] k;
  logic [KW-1:0] tone;
  logic [15:0] mix;
  logic [3:0]  envvol;
  logic [1:0]  divsel;
  logic signed [47:0] acc;
  logic        lpneg;
  psg_pkg::div_req_t dreq;
  psg_pkg::div_rsp_t drsp;

  psg_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_stall = (state != S_IDLE) || out_valid;
  assign cfg_ready = 1'b1;

  logic [7:0]  md;
  logic [15:0] per;
  logic [19:0] eper;
  logic [31:0] sph;
  logic [7:0]  en;
  logic        nen;
  logic [13:0] lvl;
  logic [7:0]  amp;
  logic [31:0] nsum;
  logic [31:0] esum;
  logic signed [47:0] dcq, dcsum, lpmag, lpq, lpsum, outp;
  logic [44:0] lpprod;

  always_comb begin
    md = data_in & psg_pkg::wmask(addr);
    per = {regs[{addr[3:1], 1'b1}], regs[{addr[3:1], 1'b0}]};
    if (addr[0]) per[15:8] = md; else per[7:0] = md;
    eper = {(addr == 4'd12 ? md : regs[12]), (addr == 4'd11 ? md : regs[11]), 4'd0};
    en = regs[7] >> ch;
    nen = en[3] | nlevel;
    sph = tph[ch] + (en[0] ? 32'd0 : tstep[ch]);
    amp = regs[{2'b10, ch}];
    lvl = amp[4] ? psg_pkg::level(envvol) : psg_pkg::level(amp[3:0]);
    nsum = nph + nstep;
    esum = eph + estep;
    // filter arithmetic, truncating toward zero
    dcq = (acc < 48'sd0) ? -((-acc) >>> 14) : (acc >>> 14);
    dcsum = $signed({32'd0, mix}) - $signed({32'd0, pmix}) + dcq;
    // divide by three as a reciprocal multiply on the magnitude
    lpmag = (acc < 48'sd0) ? -acc : acc;
    lpprod = 45'(lpmag[21:0]) * 45'd5592406;
    lpq = acc >>> 24;
    lpsum = 48'(lpv) + (lpneg ? -lpq : lpq);
    outp = 48'sd9 * 48'(lpv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      base <= psg_pkg::BASE_RESET;
      addr <= '0;
      for (int i = 0; i < 16; i++) regs[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        tph[i] <= '0;
        tstep[i] <= psg_pkg::STEP_MAX;
      end
      nph <= '0;
      nstep <= psg_pkg::STEP_MAX;
      nshift <= 17'd1;
      nlevel <= 1'b1;
      eshape <= 4'd9;
      estep <= psg_pkg::BASE_RESET >> 3;
      eph <= '0;
      dcv <= '0;
      lpv <= '0;
      pmix <= '0;
      out_valid <= 1'b0;
      dreq <= '0;
    end else begin
      if (cfg_valid) base <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            read_data <= '0;
            sample_out <= '0;
            port_write_valid <= 1'b0;
            port_select <= 1'b0;
            port_data <= '0;
            case (opcode)
              psg_pkg::OP_LATCH: begin
                addr <= data_in[3:0];
                state <= S_DONE;
              end
              psg_pkg::OP_WRITE: begin
                regs[addr] <= md;
                if (addr >= 4'd14) begin
                  port_write_valid <= 1'b1;
                  port_select <= addr[0];
                  port_data <= md;
                end
                state <= S_DONE;
                if (addr < 4'd6) begin
                  if (per > 16'd4) begin
                    dreq <= '{1'b1, base, {16'd0, per}};
                    divsel <= 2'd0;
                    ch <= addr[2:1];
                    state <= S_DIV;
                  end else tstep[addr[2:1]] <= psg_pkg::STEP_MAX;
                end else if (addr == 4'd6) begin
                  if (md > 8'd3) begin
                    dreq <= '{1'b1, base, {24'd0, md}};
                    divsel <= 2'd1;
                    state <= S_DIV;
                  end else nstep <= psg_pkg::STEP_MAX;
                end else if (addr == 4'd11 || addr == 4'd12) begin
                  dreq <= '{1'b1, base, (eper == 20'd0) ? 32'd8 : {12'd0, eper}};
                  divsel <= 2'd2;
                  state <= S_DIV;
                end else if (addr == 4'd13) begin
                  eshape <= (md < 8'd8) ? ((md < 8'd4) ? 4'd9 : 4'd15) : md[3:0];
                  eph <= '0;
                end
              end
              psg_pkg::OP_READ: begin
                if (addr >= 4'd14) begin
                  regs[addr] <= ext_port_value;
                  read_data <= ext_port_value;
                end else read_data <= regs[addr];
                state <= S_DONE;
              end
              default: begin
                nph <= nsum;
                state <= S_NOISE;
              end
            endcase
          end
        end
        S_DIV: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            case (divsel)
              2'd0: tstep[ch] <= drsp.quo;
              2'd1: nstep <= drsp.quo;
              default: estep <= drsp.quo;
            endcase
            state <= S_DONE;
          end
        end
        S_NOISE: begin
          // one shift per phase unit overflow
          if (nph[31:28] != 4'd0) begin
            nph <= nph - 32'h10000000;
            nlevel <= nlevel ^ nshift[1] ^ nshift[0];
            nshift <= 17'(({1'b0, nshift} ^ (nshift[0] ? 18'h28000 : 18'h0)) >> 1);
          end else state <= S_ENV;
        end
        S_ENV: begin
          if (eshape[0] && esum[31:28] != 4'd0) eph <= 32'h10000000;
          else eph <= esum;
          ch <= 2'd0;
          k <= '0;
          tone <= '0;
          mix <= '0;
          state <= S_TONE;
        end
        S_TONE: begin
          if (k == KW'(0)) begin
            envvol <= eph[27:24] ^ {4{(eph[28] & (eshape[0] ^ eshape[1])) ^ ~eshape[2]}};
          end
          if (k == KW'(OVERSAMPLE)) begin
            acc <= 48'(tone) * 48'(lvl);
            state <= S_MIX;
          end else begin
            tph[ch] <= sph;
            tone <= tone + KW'((en[0] | sph[31]) & nen);
            k <= k + KW'(1);
          end
        end
        S_MIX: begin
          mix <= mix + 16'(acc[47:0] / OVERSAMPLE);
          k <= '0;
          tone <= '0;
          if (ch == 2'd2) state <= S_DC1;
          else ch <= ch + 2'd1;
          if (ch != 2'd2) state <= S_TONE;
        end
        S_DC1: begin
          acc <= 48'sd16359 * 48'(dcv);
          state <= S_DC2;
        end
        S_DC2: begin
          if (dcsum > 48'sd524287) dcv <= 20'sd524287;
          else if (dcsum < -48'sd524288) dcv <= -20'sd524288;
          else dcv <= 20'(dcsum);
          pmix <= mix;
          state <= S_LP1;
        end
        S_LP1: begin
          acc <= 48'sd2 * (48'(dcv) - 48'(lpv));
          state <= S_LP2;
        end
        S_LP2: begin
          acc <= $signed({3'd0, lpprod});
          lpneg <= acc < 48'sd0;
          state <= S_LP3;
        end
        S_LP3: begin
          if (lpsum > 48'sd524287) lpv <= 20'sd524287;
          else if (lpsum < -48'sd524288) lpv <= -20'sd524288;
          else lpv <= 20'(lpsum);
          state <= S_OUT;
        end
        S_OUT: begin
          if (outp > 48'sd1048575) sample_out <= 21'sd1048575;
          else if (outp < -48'sd1048576) sample_out <= -21'sd1048576;
          else sample_out <= 21'(outp);
          state <= S_DONE;
        end
        default: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== rtl/psg_checker.sv =====
// port-level checks for the sound generator, bound to the top level
module psg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         read_data,
  input logic signed [20:0] sample_out,
  input logic               port_write_valid
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(sample_out))
    else $error("result changed under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken with result pending");
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && port_write_valid |-> read_data == 8'd0 && sample_out == 21'sd0)
    else $error("write result carries read or sample data");
endmodule

bind psg_tone_noise_envelope_mixer psg_checker u_chk (.*);
